@@ design/lzss_pkg.sv @@
`timescale 1ns / 1ps

package lzss_pkg;

  // Default history window in bytes.
  localparam int unsigned HISTORY_DEPTH_DEF = 4096;

  // Depth of the command queue between the front and the back.
  localparam int unsigned CMD_FIFO_DEPTH = 4;

  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LENGTH_W = 5;
  localparam int unsigned COUNT_W  = 17;

  localparam logic [LENGTH_W-1:0] MIN_MATCH       = 5'd3;
  localparam logic [3:0]          TOKENS_PER_FLAG = 4'd8;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 17'h1FFFF;
  localparam logic [2:0]          HDR_POS_LAST    = 3'd7;
  localparam logic [2:0]          HDR_POS_SIZE_LO = 3'd4;
  localparam logic [2:0]          HDR_POS_SIZE_HI = 3'd5;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_OK         = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_CORRUPT    = 3'd3,
    ST_MISMATCH   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_HEADER  = 2'd1,
    ERR_CORRUPT = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LIT,
    BK_COPY,
    BK_STATUS
  } back_state_e;

  // At most one command per accepted word: an optional literal or copy, then an
  // optional final status.
  typedef struct packed {
    logic                has_data;
    logic                is_copy;
    logic [7:0]          lit_byte;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic                has_status;
    status_e             status;
  } cmd_t;

  // Stream magic "TPWM".
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h54;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h57;
      default: b = 8'h4D;
    endcase
    return b;
  endfunction

endpackage

@@ design/lzss_front.sv @@
`timescale 1ns / 1ps

module lzss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output logic                ready_o,
  input  logic                full_i,
  output logic                push_o,
  output lzss_pkg::cmd_t      cmd_o
);

  logic [2:0]                     hdr_pos_q, hdr_pos_d;
  logic [15:0]                    exp_size_q, exp_size_d;
  logic [7:0]                     flag_q, flag_d;
  logic [3:0]                     tokens_q, tokens_d;
  logic                           phase_q, phase_d;
  logic [7:0]                     pend_q, pend_d;
  lzss_pkg::err_e                 err_q, err_d;
  logic [lzss_pkg::COUNT_W-1:0]   count_q, count_d;

  logic                           accept;
  logic [lzss_pkg::LENGTH_W-1:0]  ref_len;
  logic [lzss_pkg::OFFSET_W-1:0]  ref_off;
  logic                           ref_bad;
  logic [lzss_pkg::COUNT_W:0]     count_sum;
  logic [lzss_pkg::LENGTH_W-1:0]  add_len;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  // The first reference byte carries the length minus MIN_MATCH in its low
  // nibble and the top nibble of the offset in its high nibble.
  assign ref_len = lzss_pkg::LENGTH_W'(pend_q[3:0]) + lzss_pkg::MIN_MATCH;
  assign ref_off = {pend_q[7:4], byte_i};
  assign ref_bad = (ref_off == '0) ||
                   (lzss_pkg::COUNT_W'(ref_off) > count_q) ||
                   (ref_off < lzss_pkg::OFFSET_W'(ref_len));

  assign count_sum = {1'b0, count_q} + (lzss_pkg::COUNT_W + 1)'(add_len);

  always_comb begin
    hdr_pos_d  = hdr_pos_q;
    exp_size_d = exp_size_q;
    flag_d     = flag_q;
    tokens_d   = tokens_q;
    phase_d    = phase_q;
    pend_d     = pend_q;
    err_d      = err_q;
    count_d    = count_q;
    add_len    = '0;
    cmd_o      = '0;
    cmd_o.status = lzss_pkg::ST_DATA;

    if (err_q == lzss_pkg::ERR_NONE) begin
      if (hdr_pos_q < lzss_pkg::HDR_POS_SIZE_LO) begin
        if (byte_i != lzss_pkg::magic_byte(hdr_pos_q[1:0])) begin
          err_d = lzss_pkg::ERR_HEADER;
        end
      end else if (hdr_pos_q == lzss_pkg::HDR_POS_SIZE_LO) begin
        exp_size_d = {8'h00, byte_i};
      end else if (hdr_pos_q == lzss_pkg::HDR_POS_SIZE_HI) begin
        exp_size_d = {byte_i, exp_size_q[7:0]};
      end else if (tokens_q == '0) begin
        flag_d   = byte_i;
        tokens_d = lzss_pkg::TOKENS_PER_FLAG;
        phase_d  = 1'b0;
      end else if (!flag_q[7]) begin
        cmd_o.has_data = 1'b1;
        cmd_o.lit_byte = byte_i;
        add_len        = lzss_pkg::LENGTH_W'(1);
        flag_d         = {flag_q[6:0], 1'b0};
        tokens_d       = tokens_q - 4'd1;
        phase_d        = 1'b0;
      end else if (!phase_q) begin
        pend_d  = byte_i;
        phase_d = 1'b1;
      end else if (ref_bad) begin
        err_d = lzss_pkg::ERR_CORRUPT;
      end else begin
        cmd_o.has_data = 1'b1;
        cmd_o.is_copy  = 1'b1;
        cmd_o.offset   = ref_off;
        cmd_o.length   = ref_len;
        add_len        = ref_len;
        flag_d         = {flag_q[6:0], 1'b0};
        tokens_d       = tokens_q - 4'd1;
        phase_d        = 1'b0;
      end
    end

    // Produced count saturates instead of wrapping.
    if (count_sum[lzss_pkg::COUNT_W]) begin
      count_d = lzss_pkg::COUNT_MAX;
    end else begin
      count_d = count_sum[lzss_pkg::COUNT_W-1:0];
    end

    if (hdr_pos_q < lzss_pkg::HDR_POS_LAST) begin
      hdr_pos_d = hdr_pos_q + 3'd1;
    end

    if (last_i) begin
      cmd_o.has_status = 1'b1;
      if (err_d == lzss_pkg::ERR_HEADER || hdr_pos_q < lzss_pkg::HDR_POS_LAST) begin
        cmd_o.status = lzss_pkg::ST_BAD_HEADER;
      end else if (err_d == lzss_pkg::ERR_CORRUPT || tokens_d != '0 || phase_d) begin
        cmd_o.status = lzss_pkg::ST_CORRUPT;
      end else if (count_d != {1'b0, exp_size_d}) begin
        cmd_o.status = lzss_pkg::ST_MISMATCH;
      end else begin
        cmd_o.status = lzss_pkg::ST_OK;
      end
      // The stream ends here; the next word starts a fresh header.
      hdr_pos_d  = '0;
      exp_size_d = '0;
      flag_d     = '0;
      tokens_d   = '0;
      phase_d    = 1'b0;
      pend_d     = '0;
      err_d      = lzss_pkg::ERR_NONE;
      count_d    = '0;
    end
  end

  assign push_o = accept && (cmd_o.has_data || cmd_o.has_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q  <= '0;
      exp_size_q <= '0;
      flag_q     <= '0;
      tokens_q   <= '0;
      phase_q    <= 1'b0;
      pend_q     <= '0;
      err_q      <= lzss_pkg::ERR_NONE;
      count_q    <= '0;
    end else if (accept) begin
      hdr_pos_q  <= hdr_pos_d;
      exp_size_q <= exp_size_d;
      flag_q     <= flag_d;
      tokens_q   <= tokens_d;
      phase_q    <= phase_d;
      pend_q     <= pend_d;
      err_q      <= err_d;
      count_q    <= count_d;
    end
  end

endmodule

@@ design/lzss_cmd_fifo.sv @@
`timescale 1ns / 1ps

module lzss_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzss_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lzss_pkg::cmd_t head_o
);

  localparam int unsigned Depth = lzss_pkg::CMD_FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);

  lzss_pkg::cmd_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o  = (fill_q == (PtrW + 1)'(Depth));
  assign empty_o = (fill_q == '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ design/lzss_back.sv @@
`timescale 1ns / 1ps

module lzss_back #(
  parameter int unsigned HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  lzss_pkg::cmd_t  head_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [7:0]      byte_o,
  output lzss_pkg::status_e status_o,
  output logic            last_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(HISTORY_DEPTH - 1);

  lzss_pkg::back_state_e         st_q, st_d;
  lzss_pkg::cmd_t                cmd_q, cmd_d;
  logic [AW-1:0]                 wp_q, wp_d;
  logic [AW-1:0]                 rd_ptr_q, rd_ptr_d;
  logic [lzss_pkg::LENGTH_W-1:0] cnt_q, cnt_d;

  // History memory with registered read data.
  logic [7:0] hist_mem [HISTORY_DEPTH];
  logic [7:0] mem_q;
  logic       rd_en, wr_en;

  // Stage between the memory read and the output register.
  logic              stg_valid_q, stg_mem_q, stg_last_q;
  logic [7:0]        stg_byte_q;
  lzss_pkg::status_e stg_status_q;
  logic              stg_load, stg_ld_mem, stg_ld_last;
  logic [7:0]        stg_ld_byte;
  lzss_pkg::status_e stg_ld_status;
  logic [7:0]        stg_byte;

  logic              out_valid_q, out_last_q;
  logic [7:0]        out_byte_q;
  lzss_pkg::status_e out_status_q;

  logic          out_take, mv, stg_free;
  logic [AW-1:0] off_ext;
  logic [AW-1:0] start_addr;
  logic [AW:0]   wrap_addr;

  assign out_take = !out_valid_q || ready_i;
  assign mv       = stg_valid_q && out_take;
  assign stg_free = !stg_valid_q || mv;
  assign stg_byte = stg_mem_q ? mem_q : stg_byte_q;
  assign wr_en    = mv && (stg_status_q == lzss_pkg::ST_DATA);

  // Copy source: write pointer minus the offset, modulo the window.
  assign off_ext    = AW'(head_i.offset);
  assign wrap_addr  = {1'b0, wp_q} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, off_ext};
  assign start_addr = (wp_q >= off_ext) ? (wp_q - off_ext) : wrap_addr[AW-1:0];

  always_comb begin
    st_d          = st_q;
    cmd_d         = cmd_q;
    rd_ptr_d      = rd_ptr_q;
    cnt_d         = cnt_q;
    pop_o         = 1'b0;
    rd_en         = 1'b0;
    stg_load      = 1'b0;
    stg_ld_mem    = 1'b0;
    stg_ld_byte   = '0;
    stg_ld_status = lzss_pkg::ST_DATA;
    stg_ld_last   = 1'b0;
    case (st_q)
      lzss_pkg::BK_IDLE: begin
        // Start only with the stage empty, so every earlier byte is in history.
        if (!empty_i && !stg_valid_q) begin
          pop_o    = 1'b1;
          cmd_d    = head_i;
          rd_ptr_d = start_addr;
          cnt_d    = head_i.length;
          if (!head_i.has_data) begin
            st_d = lzss_pkg::BK_STATUS;
          end else if (head_i.is_copy) begin
            st_d = lzss_pkg::BK_COPY;
          end else begin
            st_d = lzss_pkg::BK_LIT;
          end
        end
      end
      lzss_pkg::BK_LIT: begin
        if (stg_free) begin
          stg_load    = 1'b1;
          stg_ld_byte = cmd_q.lit_byte;
          stg_ld_last = !cmd_q.has_status;
          st_d        = cmd_q.has_status ? lzss_pkg::BK_STATUS : lzss_pkg::BK_IDLE;
        end
      end
      lzss_pkg::BK_COPY: begin
        if (stg_free) begin
          rd_en       = 1'b1;
          stg_load    = 1'b1;
          stg_ld_mem  = 1'b1;
          stg_ld_last = (cnt_q == lzss_pkg::LENGTH_W'(1)) && !cmd_q.has_status;
          rd_ptr_d    = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
          cnt_d       = cnt_q - 1'b1;
          if (cnt_q == lzss_pkg::LENGTH_W'(1)) begin
            st_d = cmd_q.has_status ? lzss_pkg::BK_STATUS : lzss_pkg::BK_IDLE;
          end
        end
      end
      lzss_pkg::BK_STATUS: begin
        if (stg_free) begin
          stg_load      = 1'b1;
          stg_ld_status = cmd_q.status;
          stg_ld_last   = 1'b1;
          st_d          = lzss_pkg::BK_IDLE;
        end
      end
      default: begin
        st_d = lzss_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    wp_d = wp_q;
    if (wr_en) begin
      wp_d = (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
    end else if (mv) begin
      // A status word closes the stream; the next stream writes from zero.
      wp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= lzss_pkg::BK_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      wp_q     <= wp_d;
      cnt_q    <= cnt_d;
      rd_ptr_q <= rd_ptr_d;
      if (stg_load) begin
        stg_valid_q <= 1'b1;
      end else if (mv) begin
        stg_valid_q <= 1'b0;
      end
      if (mv) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (stg_load) begin
      stg_mem_q    <= stg_ld_mem;
      stg_byte_q   <= stg_ld_byte;
      stg_status_q <= stg_ld_status;
      stg_last_q   <= stg_ld_last;
    end
    if (mv) begin
      out_byte_q   <= stg_byte;
      out_status_q <= stg_status_q;
      out_last_q   <= stg_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wp_q] <= stg_byte;
    end
    if (rd_en) begin
      mem_q <= hist_mem[rd_ptr_q];
    end
  end

  assign valid_o  = out_valid_q;
  assign byte_o   = out_byte_q;
  assign status_o = out_status_q;
  assign last_o   = out_last_q;

endmodule

@@ design/lzss_stream_decompressor_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake                tdata                  tuser       tlast
// s_axis    in   s_axis_tvalid/tready     [7:0] data_byte        -           end_of_stream
// m_axis    out  m_axis_tvalid/tready     [7:0] out_byte         [2:0] status last_of_run
//
// Each input word is classified by the front in its accept cycle, so the
// front takes one word per cycle while the four-entry command queue has room.
// The back executes literals, back-references (one history read per byte)
// and status words; a command starts only once the prior byte is in history.
// Reset clears all control state; the history memory is not cleared.
// A stalled output holds its word while the back and the queue keep filling.

module lzss_stream_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // end_of_stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser_o,   // [2:0] status
  output logic       m_axis_tlast_o    // last_of_run
);

  // Commands travel from the classifier to the executor through the queue.
  logic              push, full, pop, empty;
  lzss_pkg::cmd_t    push_cmd, head_cmd;
  lzss_pkg::status_e out_status;

  lzss_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .ready_o (s_axis_tready_o),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  lzss_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  // The back owns the history window and the output register.
  lzss_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head_cmd),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .byte_o   (m_axis_tdata_o),
    .status_o (out_status),
    .last_o   (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = out_status;

endmodule
